// File: sv/rmat_edge_generator_top_macros.svh
// Assertion macros for the R-MAT edge generator.
// Used by rmat_edge_generator_top; expects i_clk and i_rst_n in scope.
`ifndef RMAT_EDGE_GENERATOR_TOP_MACROS_SVH
`define RMAT_EDGE_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define RMAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rmat_pkg.sv
// Package for the R-MAT edge generator: payload types, register codes,
// twister constants and the control state type. No dependencies.
`default_nettype none

package rmat_pkg;

    localparam int IDX_W      = 40;
    localparam int VTX_W      = 31;
    localparam int SCALE_W    = 5;
    localparam int THR_W      = 25;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MT_N       = 624;
    localparam int MT_ADDR_W  = 10;

    typedef logic [IDX_W-1:0]     t_index;
    typedef logic [VTX_W-1:0]     t_vertex;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [THR_W-1:0]     t_thr;
    typedef logic [SCALE_W-1:0]   t_scale;
    typedef logic [MT_ADDR_W-1:0] t_mt_addr;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // register indexes
    localparam t_cfg_idx CFG_SCALE     = 3'd0;
    localparam t_cfg_idx CFG_THR_A     = 3'd1;
    localparam t_cfg_idx CFG_THR_AB    = 3'd2;
    localparam t_cfg_idx CFG_THR_ABC   = 3'd3;
    localparam t_cfg_idx CFG_BASE_SEED = 3'd4;

    // register reset values
    localparam t_scale RST_SCALE     = 5'd20;
    localparam t_thr   RST_THR_A     = 25'd9563013;
    localparam t_thr   RST_THR_AB    = 25'd12750684;
    localparam t_thr   RST_THR_ABC   = 25'd15938355;
    localparam t_word  RST_BASE_SEED = 32'd27491095;

    // MT19937
    localparam t_mt_addr MT_END     = 10'd624;
    localparam t_mt_addr MT_LAST    = 10'd623;
    localparam t_mt_addr MT_M_OFS   = 10'd397;
    localparam t_mt_addr MT_WRAP_M  = 10'd227;
    localparam t_word    MT_MATRIX  = 32'h9908B0DF;
    localparam t_word    SEED_MULT  = 32'd1812433253;
    localparam t_word    TEMPER_B   = 32'h9D2C5680;
    localparam t_word    TEMPER_C   = 32'hEFC60000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_DRAW,
        ST_TW_PRIME,
        ST_TW_RD,
        ST_TW_WR,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

// File: sv/rmat_req_if.sv
// Request channel of the R-MAT edge generator: one edge index per request.
// Depends on rmat_pkg.
`default_nettype none

interface rmat_req_if;
    import rmat_pkg::*;

    logic   valid;
    logic   ready;
    t_index edge_index;

    modport source (output valid, output edge_index, input ready);
    modport sink   (input valid, input edge_index, output ready);
endinterface

`default_nettype wire

// File: sv/rmat_rsp_if.sv
// Result channel of the R-MAT edge generator: one source/destination pair.
// Depends on rmat_pkg.
`default_nettype none

interface rmat_rsp_if;
    import rmat_pkg::*;

    logic    valid;
    logic    ready;
    t_vertex source_vertex;
    t_vertex dest_vertex;

    modport source (output valid, output source_vertex, output dest_vertex, input ready);
    modport sink   (input valid, input source_vertex, input dest_vertex, output ready);
endinterface

`default_nettype wire

// File: sv/rmat_edge_generator_top.sv
// Each edge uses levels = min(scale, MAX_SCALE) draws, one twister word read per cycle
// from the 624-word state memory while no twist is due.
// Reseed (first request, block start, block change) writes the seed as word 0, then each later
// word in a multiply and an add state. A twist (prime, then a read and a write per word) runs
// every 624 draws, one is due right after each reseed, and requests are taken only when idle.
// Reset: synchronous, active low; registers to defaults, next request reseeds.
`default_nettype none
`include "rmat_edge_generator_top_macros.svh"

module rmat_edge_generator_top #(
    parameter int MAX_SCALE  = 31,
    parameter int BLOCK_BITS = 18
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [rmat_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rmat_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rmat_req_if.sink                          i_req,
    rmat_rsp_if.source                        o_rsp
);
    import rmat_pkg::*;

    localparam int BLK_W = IDX_W - BLOCK_BITS;

    function automatic t_word temper(input t_word x);
        t_word y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // configuration
    t_scale r_scale;
    t_thr   r_thr_a, r_thr_ab, r_thr_abc;
    t_word  r_base_seed;

    // control and datapath
    t_state           r_state, n_state;
    logic             r_seeded, n_seeded;
    logic [BLK_W-1:0] r_cur_blk, n_cur_blk;
    t_mt_addr         r_pos, n_pos;
    t_mt_addr         r_i, n_i;
    t_word            r_prev, n_prev;
    t_word            r_prod, n_prod;
    t_word            r_cur, n_cur;
    t_scale           r_iss, n_iss;
    t_scale           r_use, n_use;
    logic             r_rd_vld, n_rd_vld;
    t_vertex          r_src, n_src;
    t_vertex          r_dst, n_dst;
    t_vertex          r_out_src, n_out_src;
    t_vertex          r_out_dst, n_out_dst;
    logic             r_out_vld, n_out_vld;

    // twister memory
    t_word    r_mem [MT_N];
    t_word    r_q_a, r_q_b;
    logic     w_mem_we;
    t_mt_addr w_mem_wa, w_rd_a, w_rd_b;
    t_word    w_mem_wd;

    logic             w_req_fire, w_reseed, w_starts, w_issue, w_twist_due, w_load_out;
    logic [BLK_W-1:0] w_blk;
    t_scale           w_levels;
    t_word            w_seed_x, w_seed_word, w_tmp, w_y, w_tw_val;
    logic [THR_W-1:0] w_frac;
    logic             w_src_bit, w_dst_bit;

    assign w_req_fire  = i_req.valid && i_req.ready;
    assign w_blk       = i_req.edge_index[IDX_W-1:BLOCK_BITS];
    assign w_starts    = (i_req.edge_index[BLOCK_BITS-1:0] == '0);
    assign w_reseed    = !r_seeded || w_starts || (w_blk != r_cur_blk);
    assign w_levels    = (r_scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : r_scale;
    assign w_issue     = (r_state == ST_DRAW) && (r_iss != '0) && (r_pos < MT_END);
    assign w_twist_due = (r_iss != '0) && (r_pos >= MT_END);
    assign w_load_out  = (r_state == ST_FIN) && (!r_out_vld || o_rsp.ready);

    assign w_seed_x    = r_prev ^ (r_prev >> 30);
    assign w_seed_word = r_prod + WORD_W'(r_i);

    // tempered draw -> 24-bit fraction -> quadrant bits
    assign w_tmp  = temper(r_q_a);
    assign w_frac = {1'b0, w_tmp[WORD_W-1:8]};
    always_comb begin
        if (w_frac < r_thr_ab) begin
            w_src_bit = 1'b0;
            w_dst_bit = (w_frac > r_thr_a);
        end else begin
            w_src_bit = 1'b1;
            w_dst_bit = (w_frac > r_thr_abc);
        end
    end

    // twist of entry i: r_cur = w[i], q_a = w[i+1], q_b = w[i+M]
    assign w_y      = {r_cur[WORD_W-1], r_q_a[WORD_W-2:0]};
    assign w_tw_val = r_q_b ^ (w_y >> 1) ^ (w_y[0] ? MT_MATRIX : '0);

    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.source_vertex = r_out_src;
    assign o_rsp.dest_vertex   = r_out_dst;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_req_fire) begin
                    n_state = w_reseed ? ST_SEED_MUL : ST_DRAW;
                end
            end
            ST_SEED_MUL: n_state = ST_SEED_ADD;
            ST_SEED_ADD: n_state = (r_i == MT_LAST) ? ST_DRAW : ST_SEED_MUL;
            ST_DRAW: begin
                if (n_use == '0) begin
                    n_state = ST_FIN;
                end else if (w_twist_due) begin
                    n_state = ST_TW_PRIME;
                end
            end
            ST_TW_PRIME: n_state = ST_TW_RD;
            ST_TW_RD:    n_state = ST_TW_WR;
            ST_TW_WR:    n_state = (r_i == MT_LAST) ? ST_DRAW : ST_TW_RD;
            ST_FIN: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_seeded  = r_seeded;
        n_cur_blk = r_cur_blk;
        n_pos     = r_pos;
        n_i       = r_i;
        n_prev    = r_prev;
        n_prod    = r_prod;
        n_cur     = r_cur;
        n_iss     = r_iss;
        n_use     = r_use;
        n_rd_vld  = 1'b0;
        n_src     = r_src;
        n_dst     = r_dst;
        n_out_src = r_out_src;
        n_out_dst = r_out_dst;
        n_out_vld = r_out_vld && !o_rsp.ready;
        w_mem_we  = 1'b0;
        w_mem_wa  = r_i;
        w_mem_wd  = w_seed_word;
        w_rd_a    = r_pos;
        w_rd_b    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_req_fire) begin
                    n_iss = w_levels;
                    n_use = w_levels;
                    n_src = '0;
                    n_dst = '0;
                    if (w_reseed) begin
                        n_prev    = r_base_seed + WORD_W'(w_blk);
                        n_i       = 10'd1;
                        n_cur_blk = w_blk;
                        n_seeded  = 1'b1;
                    end
                end
            end
            ST_SEED_MUL: begin
                n_prod = w_seed_x * SEED_MULT;
                if (r_i == 10'd1) begin
                    // word 0 is the seed itself
                    w_mem_we = 1'b1;
                    w_mem_wa = '0;
                    w_mem_wd = r_prev;
                end
            end
            ST_SEED_ADD: begin
                w_mem_we = 1'b1;
                w_mem_wa = r_i;
                w_mem_wd = w_seed_word;
                n_prev   = w_seed_word;
                if (r_i == MT_LAST) begin
                    n_pos = MT_END;
                end else begin
                    n_i = r_i + 10'd1;
                end
            end
            ST_DRAW: begin
                if (r_rd_vld) begin
                    n_src = {r_src[VTX_W-2:0], w_src_bit};
                    n_dst = {r_dst[VTX_W-2:0], w_dst_bit};
                    n_use = r_use - 5'd1;
                end
                if (w_issue) begin
                    w_rd_a   = r_pos;
                    n_pos    = r_pos + 10'd1;
                    n_iss    = r_iss - 5'd1;
                    n_rd_vld = 1'b1;
                end
            end
            ST_TW_PRIME: begin
                w_rd_a = '0;
                n_i    = '0;
            end
            ST_TW_RD: begin
                if (r_i == '0) begin
                    n_cur = r_q_a;
                end
                w_rd_a = (r_i == MT_LAST) ? '0 : r_i + 10'd1;
                w_rd_b = (r_i < MT_WRAP_M) ? r_i + MT_M_OFS : r_i - MT_WRAP_M;
            end
            ST_TW_WR: begin
                w_mem_we = 1'b1;
                w_mem_wa = r_i;
                w_mem_wd = w_tw_val;
                n_cur    = r_q_a;
                if (r_i == MT_LAST) begin
                    n_pos = '0;
                end else begin
                    n_i = r_i + 10'd1;
                end
            end
            ST_FIN: begin
                if (w_load_out) begin
                    n_out_src = r_src;
                    n_out_dst = r_dst;
                    n_out_vld = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        r_q_a <= r_mem[w_rd_a];
        r_q_b <= r_mem[w_rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= RST_SCALE;
            r_thr_a     <= RST_THR_A;
            r_thr_ab    <= RST_THR_AB;
            r_thr_abc   <= RST_THR_ABC;
            r_base_seed <= RST_BASE_SEED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE:     r_scale     <= i_cfg_data[SCALE_W-1:0];
                CFG_THR_A:     r_thr_a     <= i_cfg_data[THR_W-1:0];
                CFG_THR_AB:    r_thr_ab    <= i_cfg_data[THR_W-1:0];
                CFG_THR_ABC:   r_thr_abc   <= i_cfg_data[THR_W-1:0];
                CFG_BASE_SEED: r_base_seed <= i_cfg_data[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_seeded  <= 1'b0;
            r_cur_blk <= '1;
            r_pos     <= MT_END;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_iss     <= '0;
            r_use     <= '0;
        end else begin
            r_state   <= n_state;
            r_seeded  <= n_seeded;
            r_cur_blk <= n_cur_blk;
            r_pos     <= n_pos;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            r_iss     <= n_iss;
            r_use     <= n_use;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_prev    <= n_prev;
        r_prod    <= n_prod;
        r_cur     <= n_cur;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_out_src <= n_out_src;
        r_out_dst <= n_out_dst;
    end

    `RMAT_ASSERT_NOW(a_mem_we_state, w_mem_we, (r_state == ST_SEED_ADD) || (r_state == ST_TW_WR) || ((r_state == ST_SEED_MUL) && (r_i == 10'd1)), "twister memory written outside seeding or twist")
    `RMAT_ASSERT_NOW(a_draw_in_range, w_issue, r_pos < MT_END, "draw read past the end of the twister state")
    `RMAT_ASSERT_NOW(a_use_covers_iss, r_state == ST_DRAW, r_use >= r_iss, "fewer draws pending use than pending issue")
    `RMAT_ASSERT_NEXT(a_twist_end, (r_state == ST_TW_WR) && (r_i == MT_LAST), (r_pos == '0) && (r_state == ST_DRAW), "twist did not return to draws at position zero")
    `RMAT_ASSERT_NEXT(a_result_loaded, w_load_out, o_rsp.valid, "finished edge not presented")

endmodule

`default_nettype wire
